// ===== hdl/vfss_pkg.sv =====
package vfss_pkg;

   // Field and register widths
   localparam int SAMPLE_BITS     = 24;
   localparam int STATE_BITS      = 40;
   localparam int COEF_FRAC_BITS  = 28;
   localparam int GUARD_BITS      = (STATE_BITS - SAMPLE_BITS) / 2;
   localparam int BLEND_FRAC_BITS = 16;
   localparam int COEF_BITS       = 32;
   localparam int POLE_BITS       = 29;
   localparam int BLEND_BITS      = 17;
   localparam int MODE_BITS       = 2;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int TDATA_BITS      = ((SAMPLE_BITS + 7) / 8) * 8;

   // Shared multiplier geometry: operand A is split into two partial products
   localparam int OPA_BITS  = STATE_BITS + 1;
   localparam int OPB_BITS  = COEF_BITS + 1;
   localparam int LO_BITS   = (OPA_BITS + 1) / 2;
   localparam int HI_BITS   = OPA_BITS - LO_BITS;
   localparam int PLO_BITS  = LO_BITS + 1 + OPB_BITS;
   localparam int PHI_BITS  = HI_BITS + OPB_BITS;
   localparam int PROD_BITS = OPA_BITS + OPB_BITS;
   localparam int ACC_BITS  = STATE_BITS + 2;

   // Blend constants in Q1.16, one-pole reset factor in Q1.28
   localparam logic [BLEND_BITS-1:0] BLEND_ONE       = BLEND_BITS'(65536);
   localparam logic [BLEND_BITS-1:0] BLEND_THRESHOLD = BLEND_BITS'(66);
   localparam logic [POLE_BITS-1:0]  POLE_RESET      = POLE_BITS'(268435456);

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SLOPE_MODE = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ONE_POLE   = CSR_ADDR_BITS'(1);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BLEND      = CSR_ADDR_BITS'(2);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_B0    = CSR_ADDR_BITS'(3);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_B1    = CSR_ADDR_BITS'(4);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_B2    = CSR_ADDR_BITS'(5);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_A1    = CSR_ADDR_BITS'(6);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_A2    = CSR_ADDR_BITS'(7);

   // Slope modes and operations
   localparam logic [MODE_BITS-1:0] MODE_SIX_DB = MODE_BITS'(0);
   localparam logic                 OP_CLEAR    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MLO,
      ST_MHI,
      ST_SUM,
      ST_ACC,
      ST_DONE
   } state_type;

   // One micro-op is one product plus one accumulate step
   typedef enum logic [2:0] {
      UOP_LP,
      UOP_B0,
      UOP_B1,
      UOP_A1,
      UOP_B2,
      UOP_A2,
      UOP_BL
   } uop_type;

   typedef struct packed {
      logic start;
      logic clear;
      logic is_six_db;
      logic cascade;
      logic blend_on;
      logic out_free;
   } seq_in_type;

   typedef struct packed {
      logic    ready;
      logic    load;
      logic    mlo;
      logic    mhi;
      logic    sum;
      logic    acc;
      logic    done;
      uop_type uop;
      logic    stage_two;
   } ctl_type;

endpackage

// ===== hdl/vfss_mul.sv =====
module vfss_mul (
   input  logic                                     clock,
   input  vfss_pkg::ctl_type                        ctl,
   input  logic signed [vfss_pkg::OPA_BITS-1:0]     opa,
   input  logic signed [vfss_pkg::OPB_BITS-1:0]     opb,
   input  logic                                     short_shift,
   output logic signed [vfss_pkg::STATE_BITS-1:0]   result
);

   logic signed [vfss_pkg::OPA_BITS-1:0]   opa_ff;
   logic signed [vfss_pkg::OPB_BITS-1:0]   opb_ff;
   logic                                   short_ff;
   logic signed [vfss_pkg::PLO_BITS-1:0]   plo_ff, plo_in;
   logic signed [vfss_pkg::PHI_BITS-1:0]   phi_ff, phi_in;
   logic signed [vfss_pkg::STATE_BITS-1:0] res_ff, res_in;
   logic signed [vfss_pkg::PROD_BITS-1:0]  full;
   logic signed [vfss_pkg::PROD_BITS-1:0]  shifted;
   logic [vfss_pkg::PROD_BITS-vfss_pkg::STATE_BITS:0] top_bits;

   // Partial products: low half of A as unsigned, high half signed
   assign plo_in = $signed({1'b0, opa_ff[vfss_pkg::LO_BITS-1:0]}) * opb_ff;
   assign phi_in = $signed(opa_ff[vfss_pkg::OPA_BITS-1:vfss_pkg::LO_BITS]) * opb_ff;

   // Combine, floor shift, saturate to the state range
   always_comb begin
      full = (vfss_pkg::PROD_BITS'(phi_ff) <<< vfss_pkg::LO_BITS)
           + vfss_pkg::PROD_BITS'(plo_ff);
      if (short_ff) begin
         shifted = full >>> vfss_pkg::BLEND_FRAC_BITS;
      end else begin
         shifted = full >>> vfss_pkg::COEF_FRAC_BITS;
      end
      top_bits = shifted[vfss_pkg::PROD_BITS-1:vfss_pkg::STATE_BITS-1];
      if ((top_bits == '0) || (top_bits == '1)) begin
         res_in = shifted[vfss_pkg::STATE_BITS-1:0];
      end else if (shifted[vfss_pkg::PROD_BITS-1]) begin
         res_in = {1'b1, {(vfss_pkg::STATE_BITS-1){1'b0}}};
      end else begin
         res_in = {1'b0, {(vfss_pkg::STATE_BITS-1){1'b1}}};
      end
   end

   // Advance one phase per cycle
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         opa_ff   <= opa;
         opb_ff   <= opb;
         short_ff <= short_shift;
      end
      if (ctl.mlo) begin
         plo_ff <= plo_in;
      end
      if (ctl.mhi) begin
         phi_ff <= phi_in;
      end
      if (ctl.sum) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== hdl/vfss_ctrl.sv =====
module vfss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  vfss_pkg::seq_in_type seq,
   output vfss_pkg::ctl_type    ctl
);

   vfss_pkg::state_type state_ff, state_in;
   vfss_pkg::uop_type   uop_ff, uop_in;
   logic                stage_ff, stage_in;

   // Next state and next micro-op
   always_comb begin
      state_in = state_ff;
      uop_in   = uop_ff;
      stage_in = stage_ff;
      case (state_ff)
         vfss_pkg::ST_IDLE: begin
            if (seq.start) begin
               if (seq.clear) begin
                  state_in = vfss_pkg::ST_DONE;
               end else begin
                  state_in = vfss_pkg::ST_LOAD;
                  stage_in = 1'b0;
                  uop_in   = seq.is_six_db ? vfss_pkg::UOP_LP : vfss_pkg::UOP_B0;
               end
            end
         end
         vfss_pkg::ST_LOAD: state_in = vfss_pkg::ST_MLO;
         vfss_pkg::ST_MLO:  state_in = vfss_pkg::ST_MHI;
         vfss_pkg::ST_MHI:  state_in = vfss_pkg::ST_SUM;
         vfss_pkg::ST_SUM:  state_in = vfss_pkg::ST_ACC;
         vfss_pkg::ST_ACC: begin
            state_in = vfss_pkg::ST_LOAD;
            case (uop_ff)
               vfss_pkg::UOP_LP: begin
                  if (seq.blend_on) begin
                     uop_in = vfss_pkg::UOP_B0;
                  end else begin
                     state_in = vfss_pkg::ST_DONE;
                  end
               end
               vfss_pkg::UOP_B0: uop_in = vfss_pkg::UOP_B1;
               vfss_pkg::UOP_B1: uop_in = vfss_pkg::UOP_A1;
               vfss_pkg::UOP_A1: uop_in = vfss_pkg::UOP_B2;
               vfss_pkg::UOP_B2: uop_in = vfss_pkg::UOP_A2;
               vfss_pkg::UOP_A2: begin
                  if (seq.is_six_db) begin
                     uop_in = vfss_pkg::UOP_BL;
                  end else if (seq.cascade && !stage_ff) begin
                     uop_in   = vfss_pkg::UOP_B0;
                     stage_in = 1'b1;
                  end else begin
                     state_in = vfss_pkg::ST_DONE;
                  end
               end
               default: state_in = vfss_pkg::ST_DONE;
            endcase
         end
         vfss_pkg::ST_DONE: begin
            if (seq.out_free) begin
               state_in = vfss_pkg::ST_IDLE;
            end
         end
         default: state_in = vfss_pkg::ST_IDLE;
      endcase
   end

   // Decode phase strobes
   always_comb begin
      ctl           = '0;
      ctl.uop       = uop_ff;
      ctl.stage_two = stage_ff;
      case (state_ff)
         vfss_pkg::ST_IDLE: ctl.ready = 1'b1;
         vfss_pkg::ST_LOAD: ctl.load  = 1'b1;
         vfss_pkg::ST_MLO:  ctl.mlo   = 1'b1;
         vfss_pkg::ST_MHI:  ctl.mhi   = 1'b1;
         vfss_pkg::ST_SUM:  ctl.sum   = 1'b1;
         vfss_pkg::ST_ACC:  ctl.acc   = 1'b1;
         vfss_pkg::ST_DONE: ctl.done  = 1'b1;
         default:           ctl.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vfss_pkg::ST_IDLE;
         uop_ff   <= vfss_pkg::UOP_LP;
         stage_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         uop_ff   <= uop_in;
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== hdl/voice_filter_selectable_slope_top.sv =====
// A sample takes N products between input transfer and result valid:
//   six dB without blend N=1, six dB with blend N=7, twelve dB N=5, cascade N=10.
// A clear runs no products and its result is zero. A new sample is taken only after the last
//   result is loaded for output, at a pace set by the single shared multiplier (two partial
//   products, combine, accumulate per product). Reset is synchronous, active high: configuration
//   registers return to defaults, filter state is zeroed at once, no clearing pass.
module voice_filter_selectable_slope_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [vfss_pkg::TDATA_BITS-1:0]        req_tdata,  // sample_in
   input  logic [0:0]                             req_tuser,  // op
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [vfss_pkg::TDATA_BITS-1:0]        rsp_tdata,  // sample_out
   output logic [0:0]                             rsp_tuser,  // saturated
   input  logic                                   csr_we,
   input  logic [vfss_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [vfss_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int SB = vfss_pkg::STATE_BITS;
   localparam int AB = vfss_pkg::ACC_BITS;

   function automatic logic signed [SB-1:0] sat_state(input logic signed [AB-1:0] v);
      logic [AB-SB:0] top_bits;
      top_bits = v[AB-1:SB-1];
      if ((top_bits == '0) || (top_bits == '1)) begin
         sat_state = v[SB-1:0];
      end else if (v[AB-1]) begin
         sat_state = {1'b1, {(SB-1){1'b0}}};
      end else begin
         sat_state = {1'b0, {(SB-1){1'b1}}};
      end
   endfunction

   // Configuration registers
   logic [vfss_pkg::MODE_BITS-1:0]         mode_ff;
   logic [vfss_pkg::POLE_BITS-1:0]         pole_ff;
   logic [vfss_pkg::BLEND_BITS-1:0]        blend_ff;
   logic signed [vfss_pkg::COEF_BITS-1:0]  b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   // Filter state and working registers
   logic signed [SB-1:0] lp_ff, s1a_ff, s1b_ff, s2a_ff, s2b_ff;
   logic signed [SB-1:0] x_ff, v_ff, y_ff;
   logic signed [AB-1:0] acc_ff;

   // Result register
   logic                              rsp_valid_ff;
   logic [vfss_pkg::SAMPLE_BITS-1:0]  out_sample_ff, out_sample_in;
   logic                              out_sat_ff, out_sat_in;

   vfss_pkg::seq_in_type seq;
   vfss_pkg::ctl_type    ctl;

   logic                                   start, out_free, load_out;
   logic signed [SB-1:0]                   x_in, za, zb, mul_result, sum_sat;
   logic signed [AB-1:0]                   prod, sum;
   logic signed [vfss_pkg::OPA_BITS-1:0]   opa;
   logic signed [vfss_pkg::OPB_BITS-1:0]   opb;
   logic [vfss_pkg::BLEND_BITS-1:0]        weight;
   logic [SB-vfss_pkg::SAMPLE_BITS-vfss_pkg::GUARD_BITS:0] out_top;

   assign start    = req_tvalid && ctl.ready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_out = ctl.done && out_free;

   assign seq.start     = start;
   assign seq.clear     = (req_tuser[0] == vfss_pkg::OP_CLEAR);
   assign seq.is_six_db = (mode_ff == vfss_pkg::MODE_SIX_DB);
   assign seq.cascade   = mode_ff[1];
   assign seq.blend_on  = (blend_ff >= vfss_pkg::BLEND_THRESHOLD);
   assign seq.out_free  = out_free;

   vfss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .seq   (seq),
      .ctl   (ctl)
   );

   // Scale the sample into the state format, clamp the blend weight, pick the stage memory
   assign x_in = SB'($signed(req_tdata[vfss_pkg::SAMPLE_BITS-1:0])) <<< vfss_pkg::GUARD_BITS;
   assign weight = (blend_ff > vfss_pkg::BLEND_ONE) ? vfss_pkg::BLEND_ONE : blend_ff;
   assign za = ctl.stage_two ? s2a_ff : s1a_ff;
   assign zb = ctl.stage_two ? s2b_ff : s1b_ff;

   // Select multiplier operands for the current micro-op
   always_comb begin
      case (ctl.uop)
         vfss_pkg::UOP_LP: begin
            opa = vfss_pkg::OPA_BITS'(sat_state(AB'(x_ff) - AB'(lp_ff)));
            opb = $signed({{(vfss_pkg::OPB_BITS-vfss_pkg::POLE_BITS){1'b0}}, pole_ff});
         end
         vfss_pkg::UOP_B0: begin
            opa = vfss_pkg::OPA_BITS'(v_ff);
            opb = vfss_pkg::OPB_BITS'(b0_ff);
         end
         vfss_pkg::UOP_B1: begin
            opa = vfss_pkg::OPA_BITS'(v_ff);
            opb = vfss_pkg::OPB_BITS'(b1_ff);
         end
         vfss_pkg::UOP_A1: begin
            opa = vfss_pkg::OPA_BITS'(y_ff);
            opb = vfss_pkg::OPB_BITS'(a1_ff);
         end
         vfss_pkg::UOP_B2: begin
            opa = vfss_pkg::OPA_BITS'(v_ff);
            opb = vfss_pkg::OPB_BITS'(b2_ff);
         end
         vfss_pkg::UOP_A2: begin
            opa = vfss_pkg::OPA_BITS'(y_ff);
            opb = vfss_pkg::OPB_BITS'(a2_ff);
         end
         vfss_pkg::UOP_BL: begin
            opa = vfss_pkg::OPA_BITS'(y_ff) - vfss_pkg::OPA_BITS'(lp_ff);
            opb = $signed({{(vfss_pkg::OPB_BITS-vfss_pkg::BLEND_BITS){1'b0}}, weight});
         end
         default: begin
            opa = vfss_pkg::OPA_BITS'(v_ff);
            opb = vfss_pkg::OPB_BITS'(b0_ff);
         end
      endcase
   end

   vfss_mul u_mul (
      .clock       (clock),
      .ctl         (ctl),
      .opa         (opa),
      .opb         (opb),
      .short_shift (ctl.uop == vfss_pkg::UOP_BL),
      .result      (mul_result)
   );

   // Accumulate the product
   assign prod = AB'(mul_result);
   always_comb begin
      case (ctl.uop)
         vfss_pkg::UOP_LP: sum = AB'(lp_ff) + prod;
         vfss_pkg::UOP_BL: sum = AB'(lp_ff) + prod;
         vfss_pkg::UOP_B0: sum = AB'(za) + prod;
         vfss_pkg::UOP_B1: sum = AB'(zb) + prod;
         vfss_pkg::UOP_A1: sum = acc_ff - prod;
         vfss_pkg::UOP_A2: sum = acc_ff - prod;
         vfss_pkg::UOP_B2: sum = prod;
         default:          sum = prod;
      endcase
   end
   assign sum_sat = sat_state(sum);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= vfss_pkg::MODE_SIX_DB;
         pole_ff  <= vfss_pkg::POLE_RESET;
         blend_ff <= '0;
         b0_ff    <= '0;
         b1_ff    <= '0;
         b2_ff    <= '0;
         a1_ff    <= '0;
         a2_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            vfss_pkg::CSR_SLOPE_MODE: mode_ff  <= csr_wdata[vfss_pkg::MODE_BITS-1:0];
            vfss_pkg::CSR_ONE_POLE:   pole_ff  <= csr_wdata[vfss_pkg::POLE_BITS-1:0];
            vfss_pkg::CSR_BLEND:      blend_ff <= csr_wdata[vfss_pkg::BLEND_BITS-1:0];
            vfss_pkg::CSR_COEF_B0:    b0_ff    <= $signed(csr_wdata[vfss_pkg::COEF_BITS-1:0]);
            vfss_pkg::CSR_COEF_B1:    b1_ff    <= $signed(csr_wdata[vfss_pkg::COEF_BITS-1:0]);
            vfss_pkg::CSR_COEF_B2:    b2_ff    <= $signed(csr_wdata[vfss_pkg::COEF_BITS-1:0]);
            vfss_pkg::CSR_COEF_A1:    a1_ff    <= $signed(csr_wdata[vfss_pkg::COEF_BITS-1:0]);
            vfss_pkg::CSR_COEF_A2:    a2_ff    <= $signed(csr_wdata[vfss_pkg::COEF_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // Filter state: zero on reset and clear, write back after the one-pole and feedback accumulates
   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff  <= '0;
         s1a_ff <= '0;
         s1b_ff <= '0;
         s2a_ff <= '0;
         s2b_ff <= '0;
      end else if (start && seq.clear) begin
         lp_ff  <= '0;
         s1a_ff <= '0;
         s1b_ff <= '0;
         s2a_ff <= '0;
         s2b_ff <= '0;
      end else if (ctl.acc) begin
         case (ctl.uop)
            vfss_pkg::UOP_LP: lp_ff <= sum_sat;
            vfss_pkg::UOP_A1: begin
               if (ctl.stage_two) begin
                  s2a_ff <= sum_sat;
               end else begin
                  s1a_ff <= sum_sat;
               end
            end
            vfss_pkg::UOP_A2: begin
               if (ctl.stage_two) begin
                  s2b_ff <= sum_sat;
               end else begin
                  s1b_ff <= sum_sat;
               end
            end
            default: ;
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x_in;
         v_ff <= x_in;
         if (seq.clear) begin
            y_ff <= '0;
         end
      end else if (ctl.acc) begin
         case (ctl.uop)
            vfss_pkg::UOP_LP: y_ff   <= sum_sat;
            vfss_pkg::UOP_B0: y_ff   <= sum_sat;
            vfss_pkg::UOP_BL: y_ff   <= sum_sat;
            vfss_pkg::UOP_B1: acc_ff <= sum;
            vfss_pkg::UOP_B2: acc_ff <= sum;
            vfss_pkg::UOP_A2: begin
               // stage one output feeds the second stage
               if (!ctl.stage_two) begin
                  v_ff <= y_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Drop guard bits with floor and clip to the sample range
   always_comb begin
      out_top = y_ff[SB-1:vfss_pkg::SAMPLE_BITS+vfss_pkg::GUARD_BITS-1];
      if ((out_top == '0) || (out_top == '1)) begin
         out_sample_in = y_ff[vfss_pkg::SAMPLE_BITS+vfss_pkg::GUARD_BITS-1:vfss_pkg::GUARD_BITS];
         out_sat_in    = 1'b0;
      end else if (y_ff[SB-1]) begin
         out_sample_in = {1'b1, {(vfss_pkg::SAMPLE_BITS-1){1'b0}}};
         out_sat_in    = 1'b1;
      end else begin
         out_sample_in = {1'b0, {(vfss_pkg::SAMPLE_BITS-1){1'b1}}};
         out_sat_in    = 1'b1;
      end
   end

   // Hold the result until the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_sample_ff <= out_sample_in;
         out_sat_ff    <= out_sat_in;
      end
   end

   assign req_tready   = ctl.ready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = vfss_pkg::TDATA_BITS'(out_sample_ff);
   assign rsp_tuser[0] = out_sat_ff;

endmodule

// ===== bench/tb_voice_filter_selectable_slope_top.sv =====
`timescale 1ns / 100ps

module tb_voice_filter_selectable_slope_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 64;
   localparam int MAX_REPORTS    = 30;

   localparam int MB = vfss_pkg::MODE_BITS;
   localparam int PB = vfss_pkg::POLE_BITS;
   localparam int BB = vfss_pkg::BLEND_BITS;
   localparam int CB = vfss_pkg::COEF_BITS;
   localparam int SMB = vfss_pkg::SAMPLE_BITS;
   localparam int AWB = vfss_pkg::CSR_ADDR_BITS;
   localparam int DWB = vfss_pkg::CSR_DATA_BITS;

   // Slope codes beyond the six dB one that the package names
   localparam logic [MB-1:0] MODE_TWELVE_DB = MB'(1);
   localparam logic [MB-1:0] MODE_CASCADE   = MB'(2);
   localparam logic [MB-1:0] MODE_SPARE     = MB'(3);
   localparam logic          OP_FILTER      = 1'b0;

   localparam longint STATE_MAX  = (longint'(1) <<< (vfss_pkg::STATE_BITS - 1)) - 1;
   localparam longint STATE_MIN  = -(longint'(1) <<< (vfss_pkg::STATE_BITS - 1));
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SMB - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SMB - 1));

   localparam logic [SMB-1:0] SMP_MAX   = SMB'(SAMPLE_MAX);
   localparam logic [SMB-1:0] SMP_MIN   = SMB'(SAMPLE_MIN);
   localparam logic [CB-1:0]  COEF_MAX  = 32'h7fff_ffff;
   localparam logic [CB-1:0]  COEF_MIN  = 32'h8000_0000;
   localparam logic [CB-1:0]  COEF_UNIT = 32'h1000_0000;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [SMB-1:0] sample_out;
      logic           saturated;
   } voice_out_type;

   typedef struct {
      logic [MB-1:0] mode;
      logic [PB-1:0] pole;
      logic [BB-1:0] blend;
      logic [CB-1:0] b0, b1, b2, a1, a2;
   } filter_cfg_type;

   // DUT ports, inputs all known from time zero
   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [vfss_pkg::TDATA_BITS-1:0] req_tdata  = '0;
   logic [0:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [vfss_pkg::TDATA_BITS-1:0] rsp_tdata;
   logic [0:0]                      rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [AWB-1:0]                  csr_addr   = '0;
   logic [DWB-1:0]                  csr_wdata  = '0;

   // Filter settings as the block should hold them
   logic [MB-1:0] cur_mode  = vfss_pkg::MODE_SIX_DB;
   logic [PB-1:0] cur_pole  = vfss_pkg::POLE_RESET;
   logic [BB-1:0] cur_blend = '0;
   longint cur_b0 = 0, cur_b1 = 0, cur_b2 = 0, cur_a1 = 0, cur_a2 = 0;

   // Filter memory as the block should hold it
   longint lp_mem = 0;
   longint s1_z1 = 0, s1_z2 = 0, s2_z1 = 0, s2_z2 = 0;

   voice_out_type pending_outputs[$];

   int   tx_idle_pct     = 0;
   int   rx_idle_pct     = 0;
   int   error_count     = 0;
   int   items_sent      = 0;
   int   results_checked = 0;
   int   settings_count  = 0;
   int   quiet_cycles    = 0;
   logic hold_active     = 1'b0;
   event hold_rx;

   voice_filter_selectable_slope_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample_in
      .req_tuser  (req_tuser),   // op
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // sample_out
      .rsp_tuser  (rsp_tuser),   // saturated
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp_state(input wide_type v);
      if (v > wide_type'(STATE_MAX)) return STATE_MAX;
      if (v < wide_type'(STATE_MIN)) return STATE_MIN;
      return longint'(v);
   endfunction

   // Exact product, floor shift, clamp to the state range
   function automatic longint scaled_product(input longint a, input longint b, input int sh);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      return clamp_state(p >>> sh);
   endfunction

   // Transposed direct-form-II section with the shared coefficients
   function automatic longint biquad_step(input longint x, inout longint z1, inout longint z2);
      longint y;
      longint n1;
      longint n2;
      y  = clamp_state(wide_type'(scaled_product(x, cur_b0, vfss_pkg::COEF_FRAC_BITS))
                       + wide_type'(z1));
      n1 = scaled_product(x, cur_b1, vfss_pkg::COEF_FRAC_BITS)
         - scaled_product(y, cur_a1, vfss_pkg::COEF_FRAC_BITS) + z2;
      n2 = scaled_product(x, cur_b2, vfss_pkg::COEF_FRAC_BITS)
         - scaled_product(y, cur_a2, vfss_pkg::COEF_FRAC_BITS);
      z1 = clamp_state(wide_type'(n1));
      z2 = clamp_state(wide_type'(n2));
      return y;
   endfunction

   function automatic voice_out_type filter_sample(input logic op,
                                                   input logic [SMB-1:0] raw);
      voice_out_type r;
      longint x;
      longint y;
      longint bq;
      longint diff;
      longint w;
      longint s;
      r = '0;
      // Clear: zero all memory, result is zero
      if (op == vfss_pkg::OP_CLEAR) begin
         lp_mem = 0;
         s1_z1  = 0;
         s1_z2  = 0;
         s2_z1  = 0;
         s2_z2  = 0;
         return r;
      end
      x = longint'($signed(raw)) <<< vfss_pkg::GUARD_BITS;
      if (cur_mode == vfss_pkg::MODE_SIX_DB) begin
         diff   = clamp_state(wide_type'(x - lp_mem));
         lp_mem = clamp_state(wide_type'(lp_mem
                  + scaled_product(diff, longint'(cur_pole), vfss_pkg::COEF_FRAC_BITS)));
         y = lp_mem;
         // Below the threshold the biquad memory is left alone
         if (cur_blend >= vfss_pkg::BLEND_THRESHOLD) begin
            w  = (cur_blend > vfss_pkg::BLEND_ONE) ? longint'(vfss_pkg::BLEND_ONE)
                                                    : longint'(cur_blend);
            bq = biquad_step(x, s1_z1, s1_z2);
            y  = clamp_state(wide_type'(y
                 + scaled_product(bq - y, w, vfss_pkg::BLEND_FRAC_BITS)));
         end
      end else begin
         y = biquad_step(x, s1_z1, s1_z2);
         if (cur_mode != MODE_TWELVE_DB) y = biquad_step(y, s2_z1, s2_z2);
      end
      s = y >>> vfss_pkg::GUARD_BITS;
      if (s > SAMPLE_MAX) begin
         s = SAMPLE_MAX;
         r.saturated = 1'b1;
      end else if (s < SAMPLE_MIN) begin
         s = SAMPLE_MIN;
         r.saturated = 1'b1;
      end
      r.sample_out = s[SMB-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one item, record its expected output on the transfer edge
   task automatic send_item(input logic op, input logic [SMB-1:0] smp);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      pending_outputs.push_back(filter_sample(op, smp));
      items_sent++;
   endtask

   // Drop valid and hold until every expected output has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Write one register; write enable stays high for a following write
   task automatic write_reg(input logic [AWB-1:0] idx, input logic [DWB-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         vfss_pkg::CSR_SLOPE_MODE: cur_mode  = v[MB-1:0];
         vfss_pkg::CSR_ONE_POLE:   cur_pole  = v[PB-1:0];
         vfss_pkg::CSR_BLEND:      cur_blend = v[BB-1:0];
         vfss_pkg::CSR_COEF_B0:    cur_b0    = longint'($signed(v));
         vfss_pkg::CSR_COEF_B1:    cur_b1    = longint'($signed(v));
         vfss_pkg::CSR_COEF_B2:    cur_b2    = longint'($signed(v));
         vfss_pkg::CSR_COEF_A1:    cur_a1    = longint'($signed(v));
         vfss_pkg::CSR_COEF_A2:    cur_a2    = longint'($signed(v));
         default: ;
      endcase
   endtask

   // Load a full setting; only called with the block idle
   task automatic apply_cfg(input filter_cfg_type c);
      wait_idle();
      write_reg(vfss_pkg::CSR_SLOPE_MODE, DWB'(c.mode));
      write_reg(vfss_pkg::CSR_ONE_POLE,   DWB'(c.pole));
      write_reg(vfss_pkg::CSR_BLEND,      DWB'(c.blend));
      write_reg(vfss_pkg::CSR_COEF_B0,    c.b0);
      write_reg(vfss_pkg::CSR_COEF_B1,    c.b1);
      write_reg(vfss_pkg::CSR_COEF_B2,    c.b2);
      write_reg(vfss_pkg::CSR_COEF_A1,    c.a1);
      write_reg(vfss_pkg::CSR_COEF_A2,    c.a2);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   function automatic filter_cfg_type make_cfg(input logic [MB-1:0] mode,
                                               input logic [PB-1:0] pole,
                                               input logic [BB-1:0] blend,
                                               input logic [CB-1:0] b0, b1, b2, a1, a2);
      filter_cfg_type c;
      c.mode  = mode;
      c.pole  = pole;
      c.blend = blend;
      c.b0    = b0;
      c.b1    = b1;
      c.b2    = b2;
      c.a1    = a1;
      c.a2    = a2;
      return c;
   endfunction

   // ---------------------------------------------------------------- random values

   function automatic logic [SMB-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return SMP_MAX;
         1:       return SMP_MIN;
         2, 3, 4: return SMB'(int'($urandom_range(0, 2047)) - 1024);
         default: return SMB'($urandom);
      endcase
   endfunction

   // Mostly well-behaved coefficients within +-1.0, sometimes extremes
   function automatic logic [CB-1:0] rand_coef();
      case ($urandom_range(0, 9))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2, 3:    return CB'($urandom);
         default: return CB'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
      endcase
   endfunction

   function automatic filter_cfg_type rand_cfg();
      filter_cfg_type c;
      c.mode = MB'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
         0:       c.pole = '0;
         1:       c.pole = vfss_pkg::POLE_RESET;
         2:       c.pole = '1;
         3:       c.pole = PB'($urandom);
         default: c.pole = PB'($urandom_range(0, 32'h1000_0000));
      endcase
      case ($urandom_range(0, 9))
         0:       c.blend = '0;
         1:       c.blend = vfss_pkg::BLEND_THRESHOLD - 1'b1;
         2:       c.blend = vfss_pkg::BLEND_THRESHOLD;
         3:       c.blend = vfss_pkg::BLEND_ONE;
         4:       c.blend = BB'($urandom);
         default: c.blend = BB'($urandom_range(0, 65536));
      endcase
      c.b0 = rand_coef();
      c.b1 = rand_coef();
      c.b2 = rand_coef();
      c.a1 = rand_coef();
      c.a2 = rand_coef();
      return c;
   endfunction

   // ---------------------------------------------------------------- checker

   // Check each output transfer against the oldest expectation, then pick tready
   always @(posedge clock) begin
      voice_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_outputs.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: output with nothing expected, actual sample_out %h saturated %b",
                        $time, rsp_tdata[SMB-1:0], rsp_tuser[0]);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata[SMB-1:0] !== want.sample_out) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: sample_out mismatch, expected %h actual %h",
                           $time, want.sample_out, rsp_tdata[SMB-1:0]);
            end
            if (rsp_tuser[0] !== want.saturated) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: saturated mismatch, expected %b actual %b",
                           $time, want.saturated, rsp_tuser[0]);
            end
         end
      end
      if (hold_active) rsp_tready <= 1'b0;
      else             rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Long receiver hold-off, counted here
   initial forever begin
      @(hold_rx);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   // Stop the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // Reset values pass the input through the one-pole at 1.0
   task automatic test_reset_passthrough();
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, SMP_MIN);
      send_item(OP_FILTER, '0);
      send_item(OP_FILTER, '1);
      send_item(OP_FILTER, SMB'(1));
      send_item(OP_FILTER, 24'h555555);
      send_item(OP_FILTER, 24'haaaaaa);
      send_item(vfss_pkg::OP_CLEAR, '1);
   endtask

   // Each slope, blend around threshold and above one, saturating extremes
   task automatic test_directed_modes();
      apply_cfg(make_cfg(MODE_TWELVE_DB, vfss_pkg::POLE_RESET, '0,
                         COEF_UNIT, COEF_MAX, COEF_MIN, '0, '0));
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, SMP_MIN);
      send_item(OP_FILTER, SMB'(1000));

      apply_cfg(make_cfg(MODE_CASCADE, vfss_pkg::POLE_RESET, '0,
                         COEF_MAX, COEF_UNIT, COEF_UNIT, COEF_MIN, COEF_MAX));
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, SMP_MIN);

      // Unused slope code runs the cascade
      apply_cfg(make_cfg(MODE_SPARE, vfss_pkg::POLE_RESET, '0,
                         COEF_MAX, COEF_UNIT, COEF_UNIT, COEF_MIN, COEF_MAX));
      send_item(OP_FILTER, SMP_MIN);
      send_item(OP_FILTER, SMP_MAX);
      send_item(vfss_pkg::OP_CLEAR, '0);

      // One-pole factor above one, blend just below the threshold
      apply_cfg(make_cfg(vfss_pkg::MODE_SIX_DB, '1, vfss_pkg::BLEND_THRESHOLD - 1'b1,
                         COEF_UNIT, COEF_UNIT, '0, '0, '0));
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, SMP_MIN);

      // Zero factor with blend at the threshold, then blend above one
      apply_cfg(make_cfg(vfss_pkg::MODE_SIX_DB, '0, vfss_pkg::BLEND_THRESHOLD,
                         COEF_UNIT, COEF_UNIT, '0, '0, '0));
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, SMB'(-12345));
      apply_cfg(make_cfg(vfss_pkg::MODE_SIX_DB, vfss_pkg::POLE_RESET >> 2, '1,
                         COEF_MAX, COEF_MIN, COEF_UNIT, COEF_UNIT, COEF_MIN));
      send_item(OP_FILTER, SMP_MIN);
      send_item(OP_FILTER, SMP_MAX);
   endtask

   // Random settings and sample streams under the current idling pattern
   task automatic test_random_traffic(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (4) begin
         apply_cfg(rand_cfg());
         repeat (42) begin
            if ($urandom_range(0, 99) < 4) send_item(vfss_pkg::OP_CLEAR, SMB'($urandom));
            else                           send_item(OP_FILTER, rand_sample());
         end
      end
   endtask

   // Stall the output long enough that the input stalls too
   task automatic test_output_backpressure();
      filter_cfg_type c;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      c = rand_cfg();
      c.mode  = vfss_pkg::MODE_SIX_DB;
      c.blend = '0;
      apply_cfg(c);
      -> hold_rx;
      repeat (12) send_item(OP_FILTER, rand_sample());
      c = rand_cfg();
      c.mode = MODE_CASCADE;
      apply_cfg(c);
      -> hold_rx;
      repeat (12) send_item(OP_FILTER, rand_sample());
      wait_idle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 9;
      rx_idle_pct = 66;
      test_reset_passthrough();
      test_directed_modes();
      test_random_traffic(9, 66);
      test_random_traffic(66, 9);
      test_random_traffic(0, 0);
      test_output_backpressure();

      // Drain and give stray outputs time to show up
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected outputs never arrived", $time, pending_outputs.size());
      end

      $display("Sent %0d samples and clears over %0d filter settings, checked %0d outputs",
               items_sent, settings_count, results_checked);
      $display("Slopes incl. spare code, blend threshold and clamp, saturation, stalls");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/vfss_pkg.sv
hdl/vfss_mul.sv
hdl/vfss_ctrl.sv
hdl/voice_filter_selectable_slope_top.sv
bench/tb_voice_filter_selectable_slope_top.sv
